[design/boe_pkg.sv]
// ----------------------------------------------------------------------------
// Binary outline extraction package
// Shared types and fixed widths for the outline front end, queue and
// result stage.
// ----------------------------------------------------------------------------
package boe_pkg;

	// Fixed field widths of the pixel and result channels.
	localparam int PIX_W     = 8;
	localparam int ROW_OUT_W = 6;
	localparam int COL_OUT_W = 3;

	// Request queue between front end and result stage; depth is a power of two.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// What the result stage does with one queued request.
	typedef enum logic [1:0] {
		KIND_PASS,   // first row: the byte itself
		KIND_MID,    // inner row: the finished byte of the row above
		KIND_LAST    // last row: the row above, then the byte itself
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic [ROW_OUT_W-1:0]   row;
		logic [ROW_OUT_W-1:0]   row_above;
		logic [COL_OUT_W-1:0]   col;
		logic [PIX_W-1:0]       outlined;
		logic [PIX_W-1:0]       raw;
		logic                   eoi;
	} entry_t;

endpackage

[design/boe_front.sv]
// ----------------------------------------------------------------------------
// Outline front end
// Accepts pixel bytes, tracks row and byte position, keeps the two previous
// rows in a shift line and classifies and outlines each byte into a request.
// ----------------------------------------------------------------------------
module boe_front #(
	parameter int IMAGE_ROWS    = 64,
	parameter int BYTES_PER_ROW = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pixel_valid,
	output logic                         pixel_stall,
	input  logic [boe_pkg::PIX_W-1:0]    pixel_byte,
	input  logic                         q_full,
	output logic                         push,
	output boe_pkg::entry_t              push_entry
);

	localparam int ROW_W     = $clog2(IMAGE_ROWS);
	localparam int COL_W     = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
	localparam int LINE_LEN  = 2 * BYTES_PER_ROW;
	localparam int MID_TAP   = BYTES_PER_ROW - 1;
	localparam int LEFT_TAP  = BYTES_PER_ROW;
	localparam int RIGHT_TAP = (BYTES_PER_ROW > 1) ? BYTES_PER_ROW - 2 : 0;
	localparam int UP_TAP    = LINE_LEN - 1;
	localparam int RX_W      = ROW_W + boe_pkg::ROW_OUT_W;
	localparam int CX_W      = COL_W + boe_pkg::COL_OUT_W;
	localparam int PW        = boe_pkg::PIX_W;
	localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(IMAGE_ROWS - 1);
	localparam logic [ROW_W-1:0] ROW_STORE  = ROW_W'(1);
	localparam logic [COL_W-1:0] COL_LAST   = COL_W'(BYTES_PER_ROW - 1);

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [PW-1:0]    line_q [LINE_LEN];
	logic             accept;
	logic             col_first;
	logic             col_last;
	logic [PW-1:0]    mid;
	logic [PW-1:0]    up;
	logic [PW-1:0]    left;
	logic [PW-1:0]    right;
	logic [PW-1:0]    lnb;
	logic [PW-1:0]    rnb;
	logic [PW-1:0]    clear;
	logic [ROW_W-1:0] row_m1;
	logic [RX_W-1:0]  row_x;
	logic [RX_W-1:0]  row_m1_x;
	logic [CX_W-1:0]  col_x;

	// A byte is taken whenever the queue has room.
	assign pixel_stall = q_full;
	assign accept      = pixel_valid && !q_full;

	// Raster position of the next byte, wrapping at the end of the image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_q == COL_LAST) begin
				col_q <= '0;
				row_q <= (row_q == ROW_LAST) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Shift line over the last two rows; newest byte at the front.
	always_ff @(posedge clk) begin
		if (accept) begin
			line_q[0] <= pixel_byte;
			for (int i = 1; i < LINE_LEN; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	// Neighborhood of the byte one row up, with white beyond the image edges.
	assign col_first = (col_q == '0);
	assign col_last  = (col_q == COL_LAST);
	assign mid       = line_q[MID_TAP];
	assign up        = line_q[UP_TAP];
	assign left      = col_first ? '0 : line_q[LEFT_TAP];
	assign right     = col_last  ? '0 : line_q[RIGHT_TAP];
	assign lnb       = {left[0], mid[PW-1:1]};
	assign rnb       = {mid[PW-2:0], right[PW-1]};

	// Clear pixels with four black neighbors, keeping the outer pixel columns.
	assign clear = mid & up & pixel_byte & lnb & rnb
	             & {~col_first, {(PW-2){1'b1}}, ~col_last};

	// Row numbers for the results, cut to the output width.
	assign row_m1   = row_q - ROW_W'(1);
	assign row_x    = RX_W'(row_q);
	assign row_m1_x = RX_W'(row_m1);
	assign col_x    = CX_W'(col_q);

	// Build the request; the second row only fills the shift line.
	always_comb begin
		push_entry.row       = row_x[boe_pkg::ROW_OUT_W-1:0];
		push_entry.row_above = row_m1_x[boe_pkg::ROW_OUT_W-1:0];
		push_entry.col       = col_x[boe_pkg::COL_OUT_W-1:0];
		push_entry.outlined  = mid & ~clear;
		push_entry.raw       = pixel_byte;
		push_entry.eoi       = col_last;
		priority if (row_q == '0) begin
			push_entry.kind = boe_pkg::KIND_PASS;
		end else if (row_q == ROW_LAST) begin
			push_entry.kind = boe_pkg::KIND_LAST;
		end else begin
			push_entry.kind = boe_pkg::KIND_MID;
		end
	end

	assign push = accept && (row_q != ROW_STORE);

endmodule

[design/boe_queue.sv]
// ----------------------------------------------------------------------------
// Outline request queue
// Small FIFO that decouples the front end from the result stage.
// ----------------------------------------------------------------------------
module boe_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  boe_pkg::entry_t push_entry,
	output logic            full,
	output logic            q_valid,
	output boe_pkg::entry_t q_entry,
	input  logic            pop
);

	localparam logic [boe_pkg::QCNT_W-1:0] DEPTH = boe_pkg::QCNT_W'(boe_pkg::QUEUE_DEPTH);

	boe_pkg::entry_t              mem_q [boe_pkg::QUEUE_DEPTH];
	logic [boe_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [boe_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [boe_pkg::QCNT_W-1:0]   count_q;
	logic                         do_pop;

	assign full    = (count_q == DEPTH);
	assign q_valid = (count_q != '0);
	assign q_entry = mem_q[rd_ptr_q];
	assign do_pop  = pop && q_valid;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + boe_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + boe_pkg::QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + boe_pkg::QCNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - boe_pkg::QCNT_W'(1);
			end
		end
	end

	// Request storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

[design/boe_back.sv]
// ----------------------------------------------------------------------------
// Outline result stage
// Turns each queued request into one or two result bytes and holds them in
// an output register until taken.
// ----------------------------------------------------------------------------
module boe_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	input  boe_pkg::entry_t                  q_entry,
	output logic                             pop,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [boe_pkg::ROW_OUT_W-1:0]    out_row,
	output logic [boe_pkg::COL_OUT_W-1:0]    out_byte_col,
	output logic [boe_pkg::PIX_W-1:0]        out_pixels,
	output logic                             last_of_run,
	output logic                             end_of_image
);

	logic                            valid_q;
	logic                            pend_q;
	logic [boe_pkg::ROW_OUT_W-1:0]   row_q;
	logic [boe_pkg::COL_OUT_W-1:0]   col_q;
	logic [boe_pkg::PIX_W-1:0]       pix_q;
	logic                            last_q;
	logic                            eoi_q;
	logic [boe_pkg::ROW_OUT_W-1:0]   hold_row_q;
	logic [boe_pkg::COL_OUT_W-1:0]   hold_col_q;
	logic [boe_pkg::PIX_W-1:0]       hold_pix_q;
	logic                            hold_eoi_q;
	logic                            load;

	// The output register takes a new result when empty or being taken.
	assign load = !valid_q || !result_stall;
	assign pop  = load && !pend_q && q_valid;

	// Control: result valid and the pending second result of a last-row byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else if (q_valid) begin
				valid_q <= 1'b1;
				pend_q  <= (q_entry.kind == boe_pkg::KIND_LAST);
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				row_q  <= hold_row_q;
				col_q  <= hold_col_q;
				pix_q  <= hold_pix_q;
				last_q <= 1'b1;
				eoi_q  <= hold_eoi_q;
			end else if (q_valid) begin
				col_q      <= q_entry.col;
				eoi_q      <= 1'b0;
				hold_row_q <= q_entry.row;
				hold_col_q <= q_entry.col;
				hold_pix_q <= q_entry.raw;
				hold_eoi_q <= q_entry.eoi;
				unique case (q_entry.kind)
					boe_pkg::KIND_PASS: begin
						row_q  <= q_entry.row;
						pix_q  <= q_entry.raw;
						last_q <= 1'b1;
					end
					boe_pkg::KIND_MID: begin
						row_q  <= q_entry.row_above;
						pix_q  <= q_entry.outlined;
						last_q <= 1'b1;
					end
					boe_pkg::KIND_LAST: begin
						row_q  <= q_entry.row_above;
						pix_q  <= q_entry.outlined;
						last_q <= 1'b0;
					end
					default: begin
						row_q  <= q_entry.row;
						pix_q  <= q_entry.raw;
						last_q <= 1'b1;
					end
				endcase
			end
		end
	end

	assign result_valid = valid_q;
	assign out_row      = row_q;
	assign out_byte_col = col_q;
	assign out_pixels   = pix_q;
	assign last_of_run  = last_q;
	assign end_of_image = eoi_q;

endmodule

[design/binary_outline_extract.sv]
// Each result is held in the request queue and then in the output register.
// One pixel byte per cycle while the queue has room; on the last row each byte gives
// two results, so the single output register loads the next request only after both.
// A two-entry request queue lets input and output stall independently.
// Reset clears the row and byte position, the queue and the output register;
// the two-row shift line is not reset and is filled by the first two rows.
// ----------------------------------------------------------------------------
// Binary outline extraction
// Four-neighbor boundary extraction on a streamed one-bit image, eight
// pixels per byte, with interior pixels cleared where all neighbors are black.
// ----------------------------------------------------------------------------
module binary_outline_extract #(
	parameter int IMAGE_ROWS    = 64,
	parameter int BYTES_PER_ROW = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pixel_valid,
	output logic                             pixel_stall,
	input  logic [boe_pkg::PIX_W-1:0]        pixel_byte,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [boe_pkg::ROW_OUT_W-1:0]    out_row,
	output logic [boe_pkg::COL_OUT_W-1:0]    out_byte_col,
	output logic [boe_pkg::PIX_W-1:0]        out_pixels,
	output logic                             last_of_run,
	output logic                             end_of_image
);

	logic            push;
	boe_pkg::entry_t push_entry;
	logic            q_full;
	logic            q_valid;
	boe_pkg::entry_t q_entry;
	logic            pop;

	// Front end: position tracking, row storage and outline logic.
	boe_front #(
		.IMAGE_ROWS    (IMAGE_ROWS),
		.BYTES_PER_ROW (BYTES_PER_ROW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel_byte  (pixel_byte),
		.q_full      (q_full),
		.push        (push),
		.push_entry  (push_entry)
	);

	// Request queue between the two halves.
	boe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.q_valid    (q_valid),
		.q_entry    (q_entry),
		.pop        (pop)
	);

	// Result stage.
	boe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_entry      (q_entry),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_row      (out_row),
		.out_byte_col (out_byte_col),
		.out_pixels   (out_pixels),
		.last_of_run  (last_of_run),
		.end_of_image (end_of_image)
	);

endmodule

[tb/sv/binary_outline_extract_tb.sv]
// ----------------------------------------------------------------------------
// Binary outline extraction testbench
// Streams binary images into the outline block with bursty input and a
// stalling receiver, predicts every emitted byte from its own copy of the
// two-row history and compares each result field by field in order.
// ----------------------------------------------------------------------------
module binary_outline_extract_tb;

	localparam int IMG_ROWS      = 64;
	localparam int IMG_BYTES     = 8;
	localparam int IDLE_LIMIT    = 2000;
	localparam int DRAIN_SLACK   = 8;

	// Pixel density used to fill one image row.
	typedef enum logic [1:0] {
		DENS_SPARSE,
		DENS_HALF,
		DENS_DENSE,
		DENS_SOLID
	} density_t;

	// How the receiver stalls during one stretch of cycles.
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	// One expected output byte.
	typedef struct packed {
		logic [boe_pkg::ROW_OUT_W-1:0] row;
		logic [boe_pkg::COL_OUT_W-1:0] col;
		logic [boe_pkg::PIX_W-1:0]     pixels;
		logic                          last;
		logic                          eoi;
	} outline_byte_t;

	logic                          clk;
	logic                          arst_n;
	logic                          pixel_valid;
	logic                          pixel_stall;
	logic [boe_pkg::PIX_W-1:0]     pixel_byte;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	logic [boe_pkg::ROW_OUT_W-1:0] out_row;
	logic [boe_pkg::COL_OUT_W-1:0] out_byte_col;
	logic [boe_pkg::PIX_W-1:0]     out_pixels;
	logic                          last_of_run;
	logic                          end_of_image;

	// Predictor state: the two previous rows and the next input position.
	logic [boe_pkg::PIX_W-1:0] row_above_buf [IMG_BYTES];
	logic [boe_pkg::PIX_W-1:0] row_two_above_buf [IMG_BYTES];
	int               next_row;
	int               next_col;

	outline_byte_t    expected_outline_q [$];

	int               error_count;
	int               bytes_sent;
	int               bytes_checked;
	int               images_done;
	int               drain_pauses;
	int               burst_left;
	int               idle_cycles;

	stall_mode_t      stall_mode = STALL_NONE;
	int               stall_span = 0;
	logic [2:0]       stall_tick = '0;

	binary_outline_extract #(
		.IMAGE_ROWS    (IMG_ROWS),
		.BYTES_PER_ROW (IMG_BYTES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_byte   (pixel_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_row      (out_row),
		.out_byte_col (out_byte_col),
		.out_pixels   (out_pixels),
		.last_of_run  (last_of_run),
		.end_of_image (end_of_image)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Work out the bytes that one accepted pixel byte releases and advance the
	// predictor's copy of the line history and position.
	task automatic predict_outline(input logic [boe_pkg::PIX_W-1:0] below);
		logic [boe_pkg::PIX_W-1:0] up;
		logic [boe_pkg::PIX_W-1:0] mid;
		logic [boe_pkg::PIX_W-1:0] left_byte;
		logic [boe_pkg::PIX_W-1:0] right_byte;
		logic [boe_pkg::PIX_W-1:0] left_nb;
		logic [boe_pkg::PIX_W-1:0] right_nb;
		logic [boe_pkg::PIX_W-1:0] interior;
		outline_byte_t    item;
		bit               last_row;

		last_row = (next_row == IMG_ROWS - 1);
		if (next_row == 0) begin
			item = '{row: boe_pkg::ROW_OUT_W'(next_row),
				col: boe_pkg::COL_OUT_W'(next_col),
				pixels: below, last: 1'b1, eoi: 1'b0};
			expected_outline_q.push_back(item);
		end else if (next_row >= 2) begin
			up         = row_two_above_buf[next_col];
			mid        = row_above_buf[next_col];
			// The left byte of this column was already shifted, so the row above
			// now sits in the older buffer; the right byte has not moved yet.
			left_byte  = (next_col > 0) ? row_two_above_buf[next_col - 1] : '0;
			right_byte = (next_col + 1 < IMG_BYTES) ? row_above_buf[next_col + 1] : '0;
			left_nb    = {left_byte[0], mid[boe_pkg::PIX_W-1:1]};
			right_nb   = {mid[boe_pkg::PIX_W-2:0], right_byte[boe_pkg::PIX_W-1]};
			interior   = mid & up & below & left_nb & right_nb;
			// The outermost pixel columns always pass through.
			if (next_col == 0)
				interior[boe_pkg::PIX_W-1] = 1'b0;
			if (next_col == IMG_BYTES - 1)
				interior[0] = 1'b0;
			item = '{row: boe_pkg::ROW_OUT_W'(next_row - 1),
				col: boe_pkg::COL_OUT_W'(next_col),
				pixels: mid & ~interior, last: !last_row, eoi: 1'b0};
			expected_outline_q.push_back(item);
			if (last_row) begin
				item = '{row: boe_pkg::ROW_OUT_W'(next_row),
					col: boe_pkg::COL_OUT_W'(next_col),
					pixels: below, last: 1'b1, eoi: (next_col == IMG_BYTES - 1)};
				expected_outline_q.push_back(item);
			end
		end

		row_two_above_buf[next_col] = row_above_buf[next_col];
		row_above_buf[next_col]     = below;

		next_col++;
		if (next_col >= IMG_BYTES) begin
			next_col = 0;
			next_row++;
			if (next_row >= IMG_ROWS)
				next_row = 0;
		end
	endtask

	// Present one pixel byte, wait for it to be taken, then keep the burst going
	// or drop valid for a random gap.
	task automatic send_pixel_byte(input logic [boe_pkg::PIX_W-1:0] value);
		pixel_valid <= 1'b1;
		pixel_byte  <= value;
		@(posedge clk);
		while (pixel_stall !== 1'b0)
			@(posedge clk);
		predict_outline(value);
		bytes_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			pixel_valid <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 200)
				: $urandom_range(1, 24);
		end
	endtask

	// Hold the sender off until every expected byte has come out.
	task automatic pause_until_drained;
		pixel_valid <= 1'b0;
		while (expected_outline_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK)
			@(posedge clk);
		drain_pauses++;
	endtask

	// Random pixel byte of the given density.
	function automatic logic [boe_pkg::PIX_W-1:0] random_pixels(input density_t density);
		logic [boe_pkg::PIX_W-1:0] value;

		case (density)
			DENS_SPARSE: value = boe_pkg::PIX_W'($urandom) & boe_pkg::PIX_W'($urandom);
			DENS_HALF:   value = boe_pkg::PIX_W'($urandom);
			DENS_DENSE:  value = boe_pkg::PIX_W'($urandom) | boe_pkg::PIX_W'($urandom)
				| boe_pkg::PIX_W'($urandom);
			default: begin
				value = '1;
				if ($urandom_range(0, 7) == 0)
					value[$urandom_range(0, boe_pkg::PIX_W - 1)] = 1'b0;
			end
		endcase
		return value;
	endfunction

	// Stream a number of random bytes, picking a fresh density at each row start
	// and pausing for a full drain before byte pause_at (negative: never).
	task automatic send_random_bytes(input int count, input int pause_at);
		density_t density;

		density = DENS_HALF;
		for (int i = 0; i < count; i++) begin
			if (i == pause_at)
				pause_until_drained();
			if (next_col == 0)
				density = density_t'($urandom_range(0, 3));
			send_pixel_byte(random_pixels(density));
		end
	endtask

	// Opening rows with edge-heavy patterns: all black, all white, lone edge
	// pixels and alternating pixels, so both byte-boundary neighbors and the
	// fixed outer columns are hit early.
	task automatic test_edge_patterns;
		logic [boe_pkg::PIX_W-1:0] pattern [24];

		pattern = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h55, 8'hFF, 8'hFF,
			8'hFF, 8'hFF, 8'h01, 8'hFF, 8'h80, 8'hFF, 8'hAA, 8'hFF};
		foreach (pattern[i])
			send_pixel_byte(pattern[i]);
	endtask

	// Finish the first image with random rows, including the doubled last row
	// and the end-of-image flag.
	task automatic test_first_image_rest;
		send_random_bytes(IMG_ROWS * IMG_BYTES - 24, -1);
	endtask

	// Let the block run completely dry at an image boundary.
	task automatic test_idle_boundary;
		pause_until_drained();
	endtask

	// A second image right after the wrap, with one full drain somewhere inside.
	task automatic test_second_image;
		send_random_bytes(IMG_ROWS * IMG_BYTES,
			$urandom_range(2 * IMG_BYTES, IMG_ROWS * IMG_BYTES - 1));
	endtask

	task automatic report_field(input string name, input int expected, input int actual);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
		error_count++;
	endtask

	// Compare every accepted result with the oldest expected byte.
	always @(posedge clk) begin
		outline_byte_t exp_item;

		if (arst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (expected_outline_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual row %0d col %0d pixels %0d",
					$time, out_row, out_byte_col, out_pixels);
				error_count++;
			end else begin
				exp_item = expected_outline_q.pop_front();
				bytes_checked++;
				if (out_row !== exp_item.row)
					report_field("out_row", exp_item.row, out_row);
				if (out_byte_col !== exp_item.col)
					report_field("out_byte_col", exp_item.col, out_byte_col);
				if (out_pixels !== exp_item.pixels)
					report_field("out_pixels", exp_item.pixels, out_pixels);
				if (last_of_run !== exp_item.last)
					report_field("last_of_run", exp_item.last, last_of_run);
				if (end_of_image !== exp_item.eoi)
					report_field("end_of_image", exp_item.eoi, end_of_image);
				if (exp_item.eoi)
					images_done++;
			end
		end
	end

	// Receiver stall pattern: stretches of no stall, light, heavy and periodic.
	always @(posedge clk) begin
		stall_tick <= stall_tick + 3'd1;
		if (stall_span == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_span <= $urandom_range(16, 96);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			STALL_NONE:     result_stall <= 1'b0;
			STALL_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY:    result_stall <= ($urandom_range(0, 3) != 0);
			STALL_PERIODIC: result_stall <= (stall_tick >= 3'd5);
			default:        result_stall <= 1'b0;
		endcase
	end

	// Watchdog: too many cycles in a row without any transfer ends the run.
	always @(posedge clk) begin
		if ((pixel_valid === 1'b1 && pixel_stall === 1'b0) ||
			(result_valid === 1'b1 && result_stall === 1'b0)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d bytes still expected",
				$time, idle_cycles, expected_outline_q.size());
			$display("binary_outline_extract_tb: done, errors");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		arst_n      <= 1'b0;
		pixel_valid <= 1'b0;
		pixel_byte  <= '0;
		next_row      = 0;
		next_col      = 0;
		error_count   = 0;
		bytes_sent    = 0;
		bytes_checked = 0;
		images_done   = 0;
		drain_pauses  = 0;
		idle_cycles   = 0;
		burst_left    = $urandom_range(1, 24);
		foreach (row_above_buf[i]) begin
			row_above_buf[i]     = '0;
			row_two_above_buf[i] = '0;
		end

		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_patterns();
		test_first_image_rest();
		test_idle_boundary();
		test_second_image();

		// Wait for the tail, then give a stray extra result time to show up.
		pixel_valid <= 1'b0;
		while (expected_outline_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK)
			@(posedge clk);

		$display("Streamed %0d pixel bytes over %0d complete images, %0d results checked,",
			bytes_sent, images_done, bytes_checked);
		$display("with bursty input, a stalling receiver and %0d full drain pauses.",
			drain_pauses);
		if (error_count == 0) begin
			$display("binary_outline_extract_tb: done, clean");
		end else begin
			$display("binary_outline_extract_tb: done, errors");
		end
		$finish;
	end

endmodule

[binary_outline_extract.f]
design/boe_pkg.sv
design/boe_front.sv
design/boe_queue.sv
design/boe_back.sv
design/binary_outline_extract.sv
tb/sv/binary_outline_extract_tb.sv
